// ===== rtl/core/token_ngram_hash_row_address_macros.svh =====
// Assertion macros used by the checker file of the hash row address block.
`ifndef TOKEN_NGRAM_HASH_ROW_ADDRESS_MACROS_SVH
`define TOKEN_NGRAM_HASH_ROW_ADDRESS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TNHRA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TNHRA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tnhra_pkg.sv =====
// Shared types and hash multiplier constants of the hash row address block.
package tnhra_pkg;

    localparam int unsigned TOKEN_W     = 18;
    localparam int unsigned HEAD_W      = 4;
    localparam int unsigned HEADS       = 16;
    localparam int unsigned ROW_W       = 29;
    localparam int unsigned ADDR_W      = 37;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    localparam logic [TOKEN_W-1:0] VOCAB_LIMIT = 18'd248320;
    localparam logic [HEAD_W-1:0]  LAST_HEAD   = 4'd15;
    localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] HALF   = (64'h7fff_ffff_ffff_ffff / 64'd248320) / 64'd2;

    function automatic logic [63:0] splitmix(input logic [63:0] x_in);
        logic [63:0] x;
        x = x_in + GOLDEN;
        x = (x ^ (x >> 30)) * 64'hbf58_476d_1ce4_e5b9;
        x = (x ^ (x >> 27)) * 64'h94d0_49bb_1331_11eb;
        return x ^ (x >> 31);
    endfunction

    function automatic logic [63:0] odd_mult(input logic [63:0] i);
        logic [63:0] seed;
        seed = 64'd1234 + GOLDEN * (i + 64'd1);
        return 64'd2 * (splitmix(seed) % HALF) + 64'd1;
    endfunction

    localparam logic [63:0] MULT0 = odd_mult(64'd0);
    localparam logic [63:0] MULT1 = odd_mult(64'd1);
    localparam logic [63:0] MULT2 = odd_mult(64'd2);

    typedef struct packed {
        logic        bad;
        logic [63:0] bigram;
        logic [63:0] trigram;
    } tnhra_item_t;

    typedef struct packed {
        logic        valid;
        tnhra_item_t item;
    } tnhra_push_t;

endpackage

// ===== rtl/core/tnhra_front.sv =====
// Front part: token intake, history tracking and bigram/trigram mixing.
module tnhra_front
    import tnhra_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [TOKEN_W-1:0]    cfg_eos_token,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TOKEN_W-1:0]    s_token,
    input  logic                  s_restart,
    input  logic [QCNT_W-1:0]     q_count,
    output tnhra_push_t           push
);

    logic [TOKEN_W-1:0] eos_reg;
    logic [TOKEN_W-1:0] prev0_reg, prev1_reg, prev0_next, prev1_next;
    logic [1:0]         hist_reg, hist_next, hist_eff;
    logic               accept, bad_tok;
    logic [TOKEN_W-1:0] t1, t2;

    logic               f1_v_reg, f1_bad_reg;
    logic [TOKEN_W-1:0] f1_t0_reg, f1_t1_reg, f1_t2_reg;

    logic               f2_v_reg, f2_bad_reg;
    logic [49:0]        f2_lo_reg [3];
    logic [31:0]        f2_hi_reg [3];
    logic [63:0]        prod [3];
    logic [TOKEN_W-1:0] f1_tok [3];
    logic [63:0]        mult [3];
    logic [QCNT_W:0]    pending;

    assign mult[0] = MULT0;
    assign mult[1] = MULT1;
    assign mult[2] = MULT2;
    assign f1_tok[0] = f1_t0_reg;
    assign f1_tok[1] = f1_t1_reg;
    assign f1_tok[2] = f1_t2_reg;

    assign pending = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(f1_v_reg) + (QCNT_W+1)'(f2_v_reg);
    assign s_ready = pending < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;
    assign bad_tok = s_token >= VOCAB_LIMIT;

    always_comb begin
        hist_eff = s_restart ? 2'd0 : hist_reg;
        t1 = (hist_eff >= 2'd1) ? prev0_reg : eos_reg;
        t2 = (hist_eff >= 2'd2) ? prev1_reg : eos_reg;
        hist_next  = hist_reg;
        prev0_next = prev0_reg;
        prev1_next = prev1_reg;
        if (accept && !bad_tok) begin
            if (s_token == eos_reg) begin
                hist_next = 2'd0;
            end else begin
                prev1_next = prev0_reg;
                prev0_next = s_token;
                hist_next  = (hist_eff == 2'd2) ? 2'd2 : hist_eff + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eos_reg   <= '0;
            prev0_reg <= '0;
            prev1_reg <= '0;
            hist_reg  <= '0;
            f1_v_reg  <= 1'b0;
            f2_v_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                eos_reg <= cfg_eos_token;
            end
            prev0_reg <= prev0_next;
            prev1_reg <= prev1_next;
            hist_reg  <= hist_next;
            f1_v_reg  <= accept;
            f2_v_reg  <= f1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_bad_reg <= bad_tok;
        f1_t0_reg  <= s_token;
        f1_t1_reg  <= t1;
        f1_t2_reg  <= t2;
        f2_bad_reg <= f1_bad_reg;
        for (int i = 0; i < 3; i++) begin
            f2_lo_reg[i] <= 50'(f1_tok[i]) * 50'(mult[i][31:0]);
            f2_hi_reg[i] <= 32'(50'(f1_tok[i]) * 50'(mult[i][63:32]));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = 64'(f2_lo_reg[i]) + {f2_hi_reg[i], 32'd0};
        end
        push.valid        = f2_v_reg;
        push.item.bad     = f2_bad_reg;
        push.item.bigram  = prod[0] ^ prod[1];
        push.item.trigram = prod[0] ^ prod[1] ^ prod[2];
    end

endmodule

// ===== rtl/core/tnhra_queue.sv =====
// Short queue of mixed items between the front and back parts.
module tnhra_queue
    import tnhra_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tnhra_push_t       push,
    input  logic              pop,
    output logic              q_valid,
    output tnhra_item_t       q_item,
    output logic [QCNT_W-1:0] q_count
);

    tnhra_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_reg, rd_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign q_valid = cnt_reg != '0;
    assign q_item  = mem_reg[rd_reg];
    assign q_count = cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (push.valid && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push.valid && pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push.valid) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_reg] <= push.item;
        end
    end

endmodule

// ===== rtl/core/tnhra_back.sv =====
// Back part: per-head floor modulo, base offset and byte address pipeline.
module tnhra_back
    import tnhra_pkg::*;
#(
    parameter int unsigned ROW_BYTES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  tnhra_item_t       q_item,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [HEAD_W-1:0] m_head,
    output logic [ROW_W-1:0]  m_row,
    output logic [ADDR_W-1:0] m_address,
    output logic              m_bad_token,
    output logic              m_last
);

    localparam int unsigned RB_W = $clog2(ROW_BYTES + 1);
    localparam logic [RB_W-1:0] RB = RB_W'(ROW_BYTES);

    localparam logic [24:0] HEAD_PRIME [HEADS] = '{
        25'd20000003, 25'd20000023, 25'd20000033, 25'd20000047,
        25'd20000059, 25'd20000063, 25'd20000069, 25'd20000077,
        25'd20000081, 25'd20000093, 25'd20000107, 25'd20000147,
        25'd20000153, 25'd20000159, 25'd20000161, 25'd20000171};
    localparam logic [ROW_W-1:0] HEAD_BASE [HEADS] = '{
        29'd0,         29'd20000003,  29'd40000026,  29'd60000059,
        29'd80000106,  29'd100000165, 29'd120000228, 29'd140000297,
        29'd160000374, 29'd180000455, 29'd200000548, 29'd220000655,
        29'd240000802, 29'd260000955, 29'd280001114, 29'd300001275};

    logic [24:0] w_tab [HEADS][4];
    logic [24:0] k_tab [HEADS];
    logic [18:0] r_tab [HEADS];

    for (genvar g = 0; g < HEADS; g++) begin : g_head
        localparam logic [64:0] P65 = 65'(HEAD_PRIME[g]);
        localparam logic [24:0] W1 = 25'((65'd1 << 16) % P65);
        localparam logic [24:0] W2 = 25'((65'd1 << 32) % P65);
        localparam logic [24:0] W3 = 25'((65'd1 << 48) % P65);
        localparam logic [24:0] K  = 25'((65'd1 << 64) % P65);
        localparam logic [18:0] R  = 19'((65'd1 << 43) / P65);
        assign w_tab[g][0] = 25'd1;
        assign w_tab[g][1] = W1;
        assign w_tab[g][2] = W2;
        assign w_tab[g][3] = W3;
        assign k_tab[g]    = K;
        assign r_tab[g]    = R;
    end

    logic              en, issue;
    logic [HEAD_W-1:0] cnt_reg, cnt_next;
    logic [63:0]       mix;

    logic              s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic [HEAD_W-1:0] s1_h_reg, s2_h_reg, s3_h_reg, s4_h_reg, s5_h_reg;
    logic              s1_b_reg, s2_b_reg, s3_b_reg, s4_b_reg, s5_b_reg;
    logic              s1_n_reg, s2_n_reg, s3_n_reg, s4_n_reg, s5_n_reg;
    logic [40:0]       s1_p_reg [4];
    logic [42:0]       s2_v43_reg;
    logic [18:0]       s3_q_reg;
    logic [25:0]       s3_lo_reg;
    logic [25:0]       s4_r_reg;
    logic [24:0]       s5_m_reg;

    logic [37:0]       q_prod;
    logic [43:0]       qp_full;
    logic [25:0]       two_p, r_red;
    logic [25:0]       fix;
    logic [ROW_W-1:0]  row;
    logic              m_valid_reg;

    assign en    = !m_valid_reg || m_ready;
    assign issue = en && q_valid;
    assign pop   = issue && (q_item.bad || cnt_reg == LAST_HEAD);
    assign mix   = (cnt_reg < 4'd8) ? q_item.bigram : q_item.trigram;

    always_comb begin
        cnt_next = cnt_reg;
        if (pop) begin
            cnt_next = '0;
        end else if (issue) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb begin
        q_prod  = 38'(s2_v43_reg[42:24]) * 38'(r_tab[s2_h_reg]);
        qp_full = 44'(s3_q_reg) * 44'(HEAD_PRIME[s3_h_reg]);
        two_p   = {HEAD_PRIME[s4_h_reg], 1'b0};
        if (s4_r_reg >= two_p) begin
            r_red = s4_r_reg - two_p;
        end else if (s4_r_reg >= 26'(HEAD_PRIME[s4_h_reg])) begin
            r_red = s4_r_reg - 26'(HEAD_PRIME[s4_h_reg]);
        end else begin
            r_red = s4_r_reg;
        end
        if (!s5_n_reg) begin
            fix = 26'(s5_m_reg);
        end else if (s5_m_reg >= k_tab[s5_h_reg]) begin
            fix = 26'(s5_m_reg) - 26'(k_tab[s5_h_reg]);
        end else begin
            fix = 26'(s5_m_reg) + 26'(HEAD_PRIME[s5_h_reg]) - 26'(k_tab[s5_h_reg]);
        end
        row = ROW_W'(fix) + HEAD_BASE[s5_h_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            s5_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            cnt_reg     <= cnt_next;
            s1_v_reg    <= issue;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            s5_v_reg    <= s4_v_reg;
            m_valid_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_h_reg <= cnt_reg;
            s1_b_reg <= q_item.bad;
            s1_n_reg <= mix[63];
            for (int i = 0; i < 4; i++) begin
                s1_p_reg[i] <= 41'(mix[16*i +: 16]) * 41'(w_tab[cnt_reg][i]);
            end
            s2_h_reg   <= s1_h_reg;
            s2_b_reg   <= s1_b_reg;
            s2_n_reg   <= s1_n_reg;
            s2_v43_reg <= 43'(s1_p_reg[0]) + 43'(s1_p_reg[1]) + 43'(s1_p_reg[2])
                          + 43'(s1_p_reg[3]);
            s3_h_reg   <= s2_h_reg;
            s3_b_reg   <= s2_b_reg;
            s3_n_reg   <= s2_n_reg;
            s3_q_reg   <= q_prod[37:19];
            s3_lo_reg  <= s2_v43_reg[25:0];
            s4_h_reg   <= s3_h_reg;
            s4_b_reg   <= s3_b_reg;
            s4_n_reg   <= s3_n_reg;
            s4_r_reg   <= s3_lo_reg - qp_full[25:0];
            s5_h_reg   <= s4_h_reg;
            s5_b_reg   <= s4_b_reg;
            s5_n_reg   <= s4_n_reg;
            s5_m_reg   <= r_red[24:0];
            m_bad_token <= s5_b_reg;
            if (s5_b_reg) begin
                m_head    <= '0;
                m_row     <= '0;
                m_address <= '0;
                m_last    <= 1'b1;
            end else begin
                m_head    <= s5_h_reg;
                m_row     <= row;
                m_address <= ADDR_W'(row * (ROW_W+RB_W)'(RB));
                m_last    <= s5_h_reg == LAST_HEAD;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/token_ngram_hash_row_address.sv =====
// Usage: one token per transfer on the s_ channel (s_token, s_restart),
// sixteen row results per valid token on the m_ channel, one per cycle
// while m_ready is high, heads 0 to 15 in order with m_last on head 15. A
// token of 248320 or more gives a single result with m_bad_token and m_last
// set and leaves the history alone. The end-of-sequence id is written
// through cfg_valid and cfg_eos_token; cfg_ready is always high, and writes
// are to go only while idle, which the block itself does not enforce.
// The back pipeline issues a valid token as sixteen heads and an
// out-of-range token as a single result, one head a cycle while the output
// is not stalled and the queue holds an item. A token passes the mixing
// registers f1 and f2 into the queue; each head issued from it passes the
// back stages s1 to s5 and the output register. The front keeps accepting
// tokens while fewer than four are held in its two mixing stages and the
// queue together, so new tokens are taken while results are still draining.
// When m_ready is low with a result on m_valid, the whole back pipeline
// holds its contents; the queue then fills and s_ready drops.
// Reset (aresetn low, synchronous) empties the pipelines and queue, clears
// the token history and sets the end-of-sequence id to zero.
module token_ngram_hash_row_address
    import tnhra_pkg::*;
#(
    parameter int unsigned ROW_BYTES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TOKEN_W-1:0] cfg_eos_token,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [TOKEN_W-1:0] s_token,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [HEAD_W-1:0]  m_head,
    output logic [ROW_W-1:0]   m_row,
    output logic [ADDR_W-1:0]  m_address,
    output logic               m_bad_token,
    output logic               m_last
);

    tnhra_push_t        push;
    tnhra_item_t        q_item;
    logic               q_valid, pop;
    logic [QCNT_W-1:0]  q_count;

    assign cfg_ready = 1'b1;

    tnhra_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_eos_token (cfg_eos_token),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_token       (s_token),
        .s_restart     (s_restart),
        .q_count       (q_count),
        .push          (push)
    );

    tnhra_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_count (q_count)
    );

    tnhra_back #(
        .ROW_BYTES (ROW_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_head      (m_head),
        .m_row       (m_row),
        .m_address   (m_address),
        .m_bad_token (m_bad_token),
        .m_last      (m_last)
    );

endmodule

// ===== rtl/core/tnhra_checker.sv =====
// Port-level checker for the hash row address block and its bind.
`include "token_ngram_hash_row_address_macros.svh"

module tnhra_checker
    import tnhra_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [HEAD_W-1:0] m_head,
    input logic [ROW_W-1:0]  m_row,
    input logic [ADDR_W-1:0] m_address,
    input logic              m_bad_token,
    input logic              m_last
);

    `TNHRA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_head) && $stable(m_row), "result changed while stalled")
    `TNHRA_ASSERT_NOW(a_bad, aclk, aresetn, m_valid && m_bad_token, m_last && m_head == '0 && m_row == '0 && m_address == '0, "bad token result not clean")
    `TNHRA_ASSERT_NOW(a_last, aclk, aresetn, m_valid && !m_bad_token, m_last == (m_head == LAST_HEAD), "last flag not on final head")
    `TNHRA_ASSERT_NEXT(a_seq, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && !m_bad_token && m_head == HEAD_W'($past(m_head) + 1'b1), "heads of a token not back to back")

endmodule

bind token_ngram_hash_row_address tnhra_checker u_tnhra_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_head      (m_head),
    .m_row       (m_row),
    .m_address   (m_address),
    .m_bad_token (m_bad_token),
    .m_last      (m_last)
);
